// ----- hw/rtl/ctdg_pkg.sv -----
// shared constants, types and the quarter-wave sine table of the chirp tone generator
package ctdg_pkg;

  localparam int SINE_TABLE_DEPTH = 1024;  // power of two
  localparam int PHASE_BITS       = 32;

  localparam int DEPTH_BITS  = $clog2(SINE_TABLE_DEPTH);
  localparam int QUARTER     = SINE_TABLE_DEPTH / 4;
  localparam int QIDX_BITS   = DEPTH_BITS - 1;
  // q16 position within the quarter turn per table entry
  localparam int ANGLE_STEP  = 65536 / QUARTER;

  localparam int SINE_BITS   = 15;
  localparam int SCALED_BITS = 30;
  localparam int ENV_BITS    = 25;
  localparam int PROD_BITS   = SCALED_BITS + ENV_BITS;
  localparam int COUNT_BITS  = 20;

  localparam logic [ENV_BITS-1:0] ENV_ONE   = ENV_BITS'(1 << 24);
  localparam logic [ENV_BITS-1:0] SCALE_Q16 = ENV_BITS'(19661);

  localparam int ADDR_BITS = 4;
  localparam logic [1:0] REG_START_STEP = 2'd0;
  localparam logic [1:0] REG_CHIRP_STEP = 2'd1;
  localparam logic [1:0] REG_COUNT      = 2'd2;
  localparam logic [1:0] REG_ENV_STEP   = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_SCALE,
    ST_ENV
  } ctdg_state_t;

  typedef logic [SINE_BITS-1:0] quarter_table_t [QUARTER+1];

  // polynomial sine over a quarter turn, q16 in and out
  function automatic longint quarter_sine_q16(input longint z);
    longint z2;
    longint t;
    z2 = (z * z) >>> 16;
    t  = (307 * z2) >>> 16;
    t  = 5223 - t;
    t  = (t * z2) >>> 16;
    t  = 42334 - t;
    t  = (t * z2) >>> 16;
    t  = 102944 - t;
    t  = (t * z) >>> 16;
    if (t > 65536) t = 65536;
    return t;
  endfunction

  function automatic quarter_table_t build_quarter_table();
    quarter_table_t tab;
    longint m;
    for (int k = 0; k <= QUARTER; k++) begin
      m = quarter_sine_q16(longint'(k) * ANGLE_STEP) >>> 1;
      if (m > 32767) m = 32767;
      tab[k] = SINE_BITS'(m);
    end
    return tab;
  endfunction

  localparam quarter_table_t QUARTER_SINE = build_quarter_table();

endpackage

// ----- hw/rtl/chirp_tone_decay_generator.sv -----
// chirp tone burst generator: second-order phase accumulator, sine table, decaying envelope
// the result word is registered after the lookup, scale and envelope steps
// a request word is taken only while idle; the shared multiplier is used twice per word
//   (sine times 0.3, then times the envelope) after the table lookup step
// a waiting result holds the sequencer in its last step until the output register frees
// reset: configuration registers, sequencer and burst state clear, envelope returns to one, no result pending
module chirp_tone_decay_generator
  import ctdg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // request channel
  input  logic                  req_valid,
  output logic                  req_stall,
  input  logic                  restart,
  // result channel
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output logic signed [15:0]    sample_value,
  output logic                  active,
  output logic                  last_sample,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_BITS-1:0]  paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  // configuration registers
  logic [31:0]           start_phase_step;
  logic signed [31:0]    chirp_step;
  logic [COUNT_BITS-1:0] sample_count;
  logic [ENV_BITS-1:0]   envelope_step;

  // burst state
  logic [COUNT_BITS-1:0] sample_index;
  logic [PHASE_BITS-1:0] phase_acc;
  logic [PHASE_BITS-1:0] phase_inc;
  logic [ENV_BITS-1:0]   env_level;

  // working registers
  ctdg_state_t           state, state_next;
  logic [SINE_BITS-1:0]  sine_mag;
  logic                  sine_neg;
  logic                  work_active;
  logic                  work_last;
  logic [SCALED_BITS-1:0] scaled;

  // sequencer controls
  logic req_accept;
  logic out_free;
  logic load_lookup;
  logic load_scale;
  logic finish;
  logic [SCALED_BITS-1:0] mul_a;
  logic [ENV_BITS-1:0]    mul_b;
  logic [PROD_BITS-1:0]   mul_p;

  logic [PHASE_BITS-1:0] chirp_ext;
  logic [DEPTH_BITS-1:0] tab_idx;
  logic [1:0]            quad;
  logic [QIDX_BITS-1:0]  fold_idx;
  logic [SINE_BITS-1:0]  mag_out;
  logic [PHASE_BITS-1:0] start_inc;

  logic cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_phase_step <= '0;
      chirp_step       <= '0;
      sample_count     <= '0;
      envelope_step    <= '0;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        REG_START_STEP: start_phase_step <= pwdata;
        REG_CHIRP_STEP: chirp_step       <= pwdata;
        REG_COUNT:      sample_count     <= pwdata[COUNT_BITS-1:0];
        REG_ENV_STEP:   envelope_step    <= pwdata[ENV_BITS-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_START_STEP: prdata = start_phase_step;
      REG_CHIRP_STEP: prdata = chirp_step;
      REG_COUNT:      prdata = {{(32-COUNT_BITS){1'b0}}, sample_count};
      REG_ENV_STEP:   prdata = {{(32-ENV_BITS){1'b0}}, envelope_step};
    endcase
  end

  // phase width follows the package; the chirp step is sign-extended or cut to fit
  assign chirp_ext = PHASE_BITS'(longint'(chirp_step));
  assign start_inc = PHASE_BITS'(start_phase_step) + chirp_ext;

  // quarter-wave fold of the table index
  assign tab_idx  = phase_acc[PHASE_BITS-1 -: DEPTH_BITS];
  assign quad     = tab_idx[DEPTH_BITS-1 -: 2];
  assign fold_idx = quad[0] ? QIDX_BITS'(QUARTER) - {1'b0, tab_idx[DEPTH_BITS-3:0]}
                            : {1'b0, tab_idx[DEPTH_BITS-3:0]};

  // shared multiplier
  assign mul_p   = PROD_BITS'(mul_a) * PROD_BITS'(mul_b);
  assign mag_out = mul_p[PROD_BITS-1 -: SINE_BITS];  // >> 40, fits without clamping

  assign req_accept = req_valid && !req_stall;
  assign out_free   = !rsp_valid || !rsp_stall;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (req_accept) state_next = ST_LOOKUP;
      ST_LOOKUP: state_next = ST_SCALE;
      ST_SCALE:  state_next = ST_ENV;
      ST_ENV:    if (out_free) state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req_stall   = 1'b1;
    load_lookup = 1'b0;
    load_scale  = 1'b0;
    finish      = 1'b0;
    mul_a       = {{(SCALED_BITS-SINE_BITS){1'b0}}, sine_mag};
    mul_b       = SCALE_Q16;
    unique case (state)
      ST_IDLE:   req_stall = 1'b0;
      ST_LOOKUP: load_lookup = 1'b1;
      ST_SCALE:  load_scale = 1'b1;
      ST_ENV: begin
        mul_a  = scaled;
        mul_b  = env_level;
        finish = out_free;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // burst state: restart on an accepted word with restart set, advance when an active word completes
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index <= '0;
      phase_acc    <= '0;
      phase_inc    <= '0;
      env_level    <= ENV_ONE;
    end else if (req_accept && restart) begin
      sample_index <= '0;
      phase_acc    <= '0;
      phase_inc    <= start_inc;
      env_level    <= ENV_ONE;
    end else if (finish && work_active) begin
      sample_index <= sample_index + 1'b1;
      phase_acc    <= phase_acc + phase_inc;
      phase_inc    <= phase_inc + {chirp_ext[PHASE_BITS-2:0], 1'b0};
      env_level    <= (env_level > envelope_step) ? env_level - envelope_step : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_lookup) begin
      work_active <= sample_index < sample_count;
      work_last   <= ({1'b0, sample_index} + 1'b1) == {1'b0, sample_count};
      sine_mag    <= (sample_index < sample_count) ? QUARTER_SINE[fold_idx] : '0;
      sine_neg    <= quad[1];
    end
    if (load_scale) scaled <= mul_p[SCALED_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) rsp_valid <= 1'b0;
    else if (finish) rsp_valid <= 1'b1;
    else if (!rsp_stall) rsp_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      sample_value <= sine_neg ? -$signed({1'b0, mag_out}) : $signed({1'b0, mag_out});
      active       <= work_active;
      last_sample  <= work_active && work_last;
    end
  end

  // the final sample is always an active one
  a_last_active: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (!last_sample || active))
    else $error("last_sample without active");

  // an inactive word carries silence
  a_inactive_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !active) |-> (sample_value == 16'sd0))
    else $error("inactive word with nonzero sample");

  // the envelope only rises on a restart
  a_env_decays: assert property (@(posedge clk) disable iff (rst)
    !(req_accept && restart) |=> (env_level <= $past(env_level)))
    else $error("envelope rose without restart");

  // the sample index steps by at most one without a restart
  a_index_step: assert property (@(posedge clk) disable iff (rst)
    !(req_accept && restart) |=>
      (sample_index == $past(sample_index) || sample_index == $past(sample_index) + 1'b1))
    else $error("sample index jumped");

  // a word is taken only with the sequencer idle, and the lookup follows
  a_accept_seq: assert property (@(posedge clk) disable iff (rst)
    req_accept |=> (state == ST_LOOKUP))
    else $error("accepted word did not start the sequence");

endmodule

// ----- bench/tb_top.sv -----
// self-checking bench for the chirp tone burst generator: predictor, scoreboard, stimulus and idling
module tb_top;
  import ctdg_pkg::*;

  typedef struct packed {
    logic signed [15:0] value;
    logic               act;
    logic               last;
  } tone_word_t;

  // predicts the burst samples and checks each result word against the oldest one
  class tone_scoreboard;
    logic [31:0]        start_step;
    logic [31:0]        chirp;
    logic [19:0]        count;
    logic [24:0]        env_step;
    logic [19:0]        index;
    logic [31:0]        phase;
    logic [31:0]        incr;
    logic [24:0]        env;
    logic signed [15:0] sine_lut [1024];
    tone_word_t         expected_words [$];
    int                 mismatches;

    function new();
      logic [15:0] u;
      logic [63:0] z;
      logic [63:0] m;
      for (int k = 0; k < 1024; k++) begin
        u = 16'(k * 64);
        z = {48'd0, 2'b00, u[13:0]} << 2;
        if (u[14]) z = 64'd65536 - z;
        m = quarter_wave(z) >> 1;
        if (m > 64'd32767) m = 64'd32767;
        sine_lut[k] = u[15] ? -16'(m) : 16'(m);
      end
      start_step = '0;
      chirp      = '0;
      count      = '0;
      env_step   = '0;
      index      = '0;
      phase      = '0;
      incr       = '0;
      env        = 25'h100_0000;
      mismatches = 0;
    endfunction

    // odd polynomial for sin(pi/2 z), q16 in and out
    function logic [63:0] quarter_wave(logic [63:0] z);
      logic [63:0] z2;
      logic [63:0] t;
      z2 = (z * z) >> 16;
      t  = 64'd5223 - ((64'd307 * z2) >> 16);
      t  = 64'd42334 - ((t * z2) >> 16);
      t  = 64'd102944 - ((t * z2) >> 16);
      t  = (t * z) >> 16;
      if (t > 64'd65536) t = 64'd65536;
      return t;
    endfunction

    function void write_reg(logic [1:0] which, logic [31:0] value);
      case (which)
        REG_START_STEP: start_step = value;
        REG_CHIRP_STEP: chirp      = value;
        REG_COUNT:      count      = value[19:0];
        REG_ENV_STEP:   env_step   = value[24:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    function void note_request(logic rs);
      tone_word_t         w;
      logic signed [15:0] s;
      logic [63:0]        mag;
      if (rs) begin
        index = '0;
        phase = '0;
        incr  = start_step + chirp;
        env   = 25'h100_0000;
      end
      if (index >= count) begin
        w = '0;
        expected_words.push_back(w);
        return;
      end
      s   = sine_lut[phase[31:22]];
      mag = 64'(s < 0 ? -s : s) * 64'd19661 * 64'(env);
      mag = mag >> 40;
      if (mag > 64'd32767) mag = 64'd32767;
      w.value = (s < 0) ? -16'(mag) : 16'(mag);
      w.act   = 1'b1;
      w.last  = (index + 20'd1 == count);
      expected_words.push_back(w);
      index = index + 20'd1;
      phase = phase + incr;
      incr  = incr + {chirp[30:0], 1'b0};
      env   = (env > env_step) ? env - env_step : '0;
    endfunction

    function void check_result(logic signed [15:0] value, logic act, logic last);
      tone_word_t w;
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected word: sample %0d active %0b last %0b",
                   $time, value, act, last);
        return;
      end
      w = expected_words.pop_front();
      if (value !== w.value || act !== w.act || last !== w.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: got sample %0d active %0b last %0b, expected %0d %0b %0b",
                   $time, value, act, last, w.value, w.act, w.last);
      end
    endfunction
  endclass

  localparam int WATCHDOG_LIMIT = 5000;

  logic                  clk          = 1'b0;
  logic                  rst          = 1'b1;
  logic                  req_valid    = 1'b0;
  logic                  req_stall;
  logic                  restart      = 1'b0;
  logic                  rsp_valid;
  logic                  rsp_stall    = 1'b0;
  logic signed [15:0]    sample_value;
  logic                  active;
  logic                  last_sample;
  logic                  psel         = 1'b0;
  logic                  penable      = 1'b0;
  logic                  pwrite       = 1'b0;
  logic [ADDR_BITS-1:0]  paddr        = '0;
  logic [31:0]           pwdata       = '0;
  logic [31:0]           prdata;
  logic                  pready;

  tone_scoreboard sb;
  int             idle_pct   = 0;
  int             stall_pct  = 0;
  logic           hold_off   = 1'b0;
  int             quiet_cycles = 0;

  chirp_tone_decay_generator uut (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .restart      (restart),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .sample_value (sample_value),
    .active       (active),
    .last_sample  (last_sample),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    rsp_stall <= hold_off || ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) sb.check_result(sample_value, active, last_sample);
  end

  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // entered and left at a falling edge
  task automatic send_request(input logic rs);
    while ($urandom_range(0, 99) < idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    restart   <= rs;
    do @(posedge clk); while (req_stall);
    sb.note_request(rs);
    @(negedge clk);
  endtask

  task automatic write_register(input logic [1:0] which, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {which, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(which, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic program_setting(input logic [31:0] start_v, input logic [31:0] chirp_v,
                                 input logic [19:0] count_v, input logic [24:0] env_v);
    write_register(REG_START_STEP, start_v);
    write_register(REG_CHIRP_STEP, chirp_v);
    write_register(REG_COUNT, 32'(count_v));
    write_register(REG_ENV_STEP, 32'(env_v));
  endtask

  // every word gets a result, so waiting until none is pending and then idling covers the pipeline
  task automatic wait_drained();
    req_valid <= 1'b0;
    while (sb.pending() > 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic program_random_setting();
    logic [31:0] start_v;
    logic [31:0] chirp_v;
    logic [19:0] count_v;
    logic [24:0] env_v;
    case ($urandom_range(0, 5))
      0:       start_v = '0;
      1:       start_v = '1;
      default: start_v = $urandom;
    endcase
    case ($urandom_range(0, 7))
      0:       chirp_v = '0;
      1:       chirp_v = 32'h8000_0000;
      2:       chirp_v = 32'h7FFF_FFFF;
      3, 4:    chirp_v = 32'($urandom_range(0, 4000)) - 32'd2000;
      default: chirp_v = $urandom;
    endcase
    case ($urandom_range(0, 9))
      0:       count_v = '0;
      1:       count_v = 20'd1;
      2:       count_v = 20'hF_FFFF;
      default: count_v = 20'($urandom_range(2, 48));
    endcase
    case ($urandom_range(0, 5))
      0:       env_v = '0;
      1:       env_v = 25'h100_0000;
      2, 3:    env_v = (count_v == 0) ? 25'd1 : 25'(32'h100_0000 / 32'(count_v));
      default: env_v = 25'($urandom_range(0, 16777216));
    endcase
    program_setting(start_v, chirp_v, count_v, env_v);
  endtask

  // mostly bursts that run to the end, with the odd restart landing mid-burst
  task automatic run_items(input int n);
    for (int i = 0; i < n; i++) begin
      if (i == 0) send_request($urandom_range(0, 3) != 0);
      else        send_request($urandom_range(0, 15) == 0);
    end
  endtask

  initial begin
    sb = new();
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // count of zero after reset: inactive words only
    send_request(1'b0);
    send_request(1'b1);
    wait_drained();

    // extreme steps, envelope gone after one word, short burst running out
    program_setting(32'hFFFF_FFFF, 32'h8000_0000, 20'd3, 25'h100_0000);
    send_request(1'b1);
    repeat (3) send_request(1'b0);
    wait_drained();

    program_setting(32'h4000_0000, 32'h7FFF_FFFF, 20'hF_FFFF, 25'd0);
    send_request(1'b1);
    repeat (5) send_request(1'b0);
    wait_drained();

    // plain tone with restart mid-burst, then the count lowered under the index
    program_setting(32'h0100_0000, 32'd0, 20'd6, 25'd2796202);
    send_request(1'b1);
    repeat (3) send_request(1'b0);
    send_request(1'b1);
    repeat (2) send_request(1'b0);
    wait_drained();
    write_register(REG_COUNT, 32'd2);
    repeat (2) send_request(1'b0);
    wait_drained();

    for (int p = 0; p < 6; p++) begin
      case (p)
        1:       begin idle_pct = 65; stall_pct <= 0;  end
        2:       begin idle_pct = 0;  stall_pct <= 65; end
        3, 5:    begin idle_pct = 16; stall_pct <= 16; end
        default: begin idle_pct = 0;  stall_pct <= 0;  end
      endcase
      program_random_setting();
      if (p == 4) begin
        // receiver holds off long enough for the block to back up its input
        fork
          run_items(200);
          begin
            repeat (20) @(negedge clk);
            hold_off <= 1'b1;
            repeat (150) @(negedge clk);
            hold_off <= 1'b0;
          end
        join
      end else begin
        run_items(200);
      end
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
